>>> hw/rtl/mdq_pkg.sv
// Shared types, constants and the step period table of the mouse quadrature converter.
package mdq_pkg;

  localparam int unsigned DPI_DIVISOR_DEF = 2;
  localparam int unsigned DIST_BITS_DEF   = 10;

  localparam int unsigned DELTA_W   = 8;
  localparam int unsigned BTN_W     = 3;
  localparam int unsigned PERIOD_W  = 8;
  localparam int unsigned LIMIT_W   = 10;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned LUT_IDX_W = 7;
  localparam int unsigned LUT_MAX   = 127;

  localparam logic [PERIOD_W-1:0] RATE_FLOOR_RST = 8'd1;
  localparam logic [LIMIT_W-1:0]  DIST_LIMIT_RST = 10'd127;
  localparam logic [PERIOD_W-1:0] RELOAD_RST     = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DPI_DIV_EN    = 2'd0,
    REG_RATE_LIMIT_EN = 2'd1,
    REG_RATE_FLOOR    = 2'd2,
    REG_DIST_LIMIT    = 2'd3
  } mdq_reg_e;

  typedef enum logic {
    OP_REPORT = 1'b0,
    OP_TICK   = 1'b1
  } mdq_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_PUSH
  } mdq_state_e;

  typedef enum logic [1:0] {
    PH_0 = 2'd0,
    PH_1 = 2'd1,
    PH_2 = 2'd2,
    PH_3 = 2'd3
  } mdq_phase_e;

  typedef struct packed {
    logic                dpi_div_en;
    logic                rate_limit_en;
    logic [PERIOD_W-1:0] rate_floor;
    logic [LIMIT_W-1:0]  dist_limit;
  } mdq_cfg_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic load_out;
  } mdq_cmd_t;

  typedef struct packed {
    mdq_op_e                   cmd;
    logic signed [DELTA_W-1:0] dx;
    logic signed [DELTA_W-1:0] dy;
    logic [BTN_W-1:0]          buttons;
  } mdq_item_t;

  typedef struct packed {
    logic x_a;
    logic x_b;
    logic y_a;
    logic y_b;
    logic left;
    logic right;
    logic middle;
  } mdq_pins_t;

  function automatic logic [PERIOD_W-1:0] mdq_period_lut(logic [LUT_IDX_W-1:0] t);
    logic [PERIOD_W-1:0] p;
    case (t) inside
      7'd0:            p = 8'd255;
      7'd1:            p = 8'd155;
      7'd2:            p = 8'd77;
      7'd3:            p = 8'd51;
      7'd4:            p = 8'd38;
      7'd5:            p = 8'd30;
      7'd6:            p = 8'd25;
      7'd7:            p = 8'd21;
      7'd8:            p = 8'd18;
      7'd9:            p = 8'd16;
      7'd10:           p = 8'd14;
      7'd11:           p = 8'd13;
      7'd12:           p = 8'd12;
      7'd13:           p = 8'd11;
      7'd14:           p = 8'd10;
      7'd15:           p = 8'd9;
      [7'd16:7'd17]:   p = 8'd8;
      [7'd18:7'd19]:   p = 8'd7;
      [7'd20:7'd22]:   p = 8'd6;
      [7'd23:7'd26]:   p = 8'd5;
      [7'd27:7'd31]:   p = 8'd4;
      [7'd32:7'd39]:   p = 8'd3;
      [7'd40:7'd52]:   p = 8'd2;
      [7'd53:7'd78]:   p = 8'd1;
      default:         p = 8'd0;
    endcase
    return p;
  endfunction

endpackage

>>> hw/rtl/mdq_if.sv
// Valid/ready channel interfaces for input items and result pin levels.
interface mdq_item_if import mdq_pkg::*; ();
  logic                      valid;
  logic                      ready;
  mdq_op_e                   cmd;
  logic signed [DELTA_W-1:0] dx;
  logic signed [DELTA_W-1:0] dy;
  logic [BTN_W-1:0]          buttons;

  modport source (output valid, cmd, dx, dy, buttons, input ready);
  modport sink   (input valid, cmd, dx, dy, buttons, output ready);
endinterface

interface mdq_result_if;
  logic valid;
  logic ready;
  logic x_a_pin;
  logic x_b_pin;
  logic y_a_pin;
  logic y_b_pin;
  logic left_pin;
  logic right_pin;
  logic middle_pin;

  modport source (output valid, x_a_pin, x_b_pin, y_a_pin, y_b_pin, left_pin, right_pin,
                  middle_pin, input ready);
  modport sink   (input valid, x_a_pin, x_b_pin, y_a_pin, y_b_pin, left_pin, right_pin,
                  middle_pin, output ready);
endinterface

>>> hw/rtl/mouse_delta_to_quadrature_core.sv
// Top level of the mouse report to quadrature and button line converter.
//
//   channel   | dir | handshake          | payload
//   ----------+-----+--------------------+----------------------------------------
//   item_i    | in  | valid/ready        | cmd, dx, dy, buttons
//   result_o  | out | valid/ready        | x_a/x_b/y_a/y_b pins, button pins
//   cfg       | in  | cfg_we_i, no stall | cfg_idx_i, cfg_wdata_i
//
// Each transaction is captured into the item register, executes both axis lanes,
// then loads the output register; the next item is captured as the output loads.
// Reset is asynchronous and clears control, configuration and axis state; the
// item and output registers load before they are used.
// One more transaction is accepted while a result waits; the block then holds.
module mouse_delta_to_quadrature_core import mdq_pkg::*; #(
  parameter int unsigned DPI_DIVISOR   = DPI_DIVISOR_DEF,
  parameter int unsigned DISTANCE_BITS = DIST_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  mdq_item_if.sink             item_i,
  mdq_result_if.source         result_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [LIMIT_W-1:0]   cfg_wdata_i
);

  mdq_cmd_t  cmd;
  mdq_item_t item;
  mdq_pins_t pins;

  assign item.cmd     = item_i.cmd;
  assign item.dx      = item_i.dx;
  assign item.dy      = item_i.dy;
  assign item.buttons = item_i.buttons;

  mdq_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i (item_i.valid),
    .in_ready_o (item_i.ready),
    .out_valid_o(result_o.valid),
    .out_ready_i(result_o.ready),
    .cmd_o      (cmd)
  );

  mdq_datapath #(
    .DPI_DIVISOR  (DPI_DIVISOR),
    .DISTANCE_BITS(DISTANCE_BITS)
  ) u_datapath (
    .clk_i,
    .rst_ni,
    .cmd_i      (cmd),
    .item_i     (item),
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .pins_o     (pins)
  );

  assign result_o.x_a_pin    = pins.x_a;
  assign result_o.x_b_pin    = pins.x_b;
  assign result_o.y_a_pin    = pins.y_a;
  assign result_o.y_b_pin    = pins.y_b;
  assign result_o.left_pin   = pins.left;
  assign result_o.right_pin  = pins.right;
  assign result_o.middle_pin = pins.middle;

endmodule

>>> hw/rtl/mdq_axis.sv
// One axis lane: pending distance, direction, phase, step timer and its two quadrature lines.
module mdq_axis import mdq_pkg::*; #(
  parameter int unsigned DPI_DIVISOR   = DPI_DIVISOR_DEF,
  parameter int unsigned DISTANCE_BITS = DIST_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      report_i,
  input  logic                      tick_i,
  input  logic signed [DELTA_W-1:0] delta_i,
  input  mdq_cfg_t                  cfg_i,
  output logic                      first_o,
  output logic                      second_o
);

  localparam int unsigned W = ((DISTANCE_BITS > LIMIT_W) ? DISTANCE_BITS : LIMIT_W) + 1;
  localparam logic [W-1:0] CAP_MAX = W'((2 ** DISTANCE_BITS) - 1);
  localparam int unsigned DIV_SHIFT = 16;
  localparam int unsigned RECIP_W   = DIV_SHIFT + 1;
  localparam int unsigned PROD_W    = DIV_SHIFT + DELTA_W;
  localparam logic [RECIP_W-1:0] DIV_RECIP =
    RECIP_W'(((2 ** DIV_SHIFT) + DPI_DIVISOR - 1) / DPI_DIVISOR);

  logic [DISTANCE_BITS-1:0] dist_q, dist_d;
  logic                     dir_q, dir_d;
  mdq_phase_e               phase_q, phase_d;
  logic [PERIOD_W-1:0]      period_q, period_d;
  logic [PERIOD_W-1:0]      reload_q, reload_d;
  logic [PERIOD_W-1:0]      cnt_q, cnt_d;
  logic                     first_q, first_d;
  logic                     second_q, second_d;

  logic                 d_neg, d_zero, d_pos, reverse;
  logic [DELTA_W-1:0]   mag, mag_div, mag_eff;
  logic [PROD_W-1:0]    mag_prod;
  logic [W-1:0]         base, sum, lim, cap, new_dist;
  logic [LUT_IDX_W-1:0] lut_idx;
  logic [PERIOD_W-1:0]  lut_period, new_period;

  always_comb begin
    d_neg    = delta_i[DELTA_W-1];
    d_zero   = (delta_i == '0);
    d_pos    = !d_neg && !d_zero;
    reverse  = (d_pos && !dir_q) || (d_neg && dir_q);
    mag      = d_neg ? DELTA_W'(-delta_i) : DELTA_W'(delta_i);
    mag_prod = PROD_W'(mag) * PROD_W'(DIV_RECIP);
    mag_div  = mag_prod[PROD_W-1:DIV_SHIFT];
    if (cfg_i.dpi_div_en) begin
      mag_eff = (mag_div == '0) ? DELTA_W'(1) : mag_div;
    end else begin
      mag_eff = mag;
    end
    base     = reverse ? '0 : W'(dist_q);
    sum      = d_zero ? '0 : (base + W'(mag_eff));
    lim      = W'(cfg_i.dist_limit);
    cap      = (lim < CAP_MAX) ? lim : CAP_MAX;
    new_dist = (sum > cap) ? cap : sum;
    lut_idx  = (new_dist > W'(LUT_MAX)) ? LUT_IDX_W'(LUT_MAX) : new_dist[LUT_IDX_W-1:0];
    lut_period = mdq_period_lut(lut_idx);
    if (cfg_i.rate_limit_en && (lut_period < cfg_i.rate_floor)) begin
      new_period = cfg_i.rate_floor;
    end else begin
      new_period = lut_period;
    end
  end

  always_comb begin
    dist_d   = dist_q;
    dir_d    = dir_q;
    phase_d  = phase_q;
    period_d = period_q;
    reload_d = reload_q;
    cnt_d    = cnt_q;
    first_d  = first_q;
    second_d = second_q;
    if (report_i) begin
      dist_d   = new_dist[DISTANCE_BITS-1:0];
      dir_d    = d_pos ? 1'b1 : (d_neg ? 1'b0 : dir_q);
      period_d = new_period;
    end else if (tick_i) begin
      if (cnt_q >= reload_q) begin
        cnt_d    = '0;
        reload_d = (period_q == '0) ? PERIOD_W'(1) : period_q;
        if (dist_q != '0) begin
          case (phase_q)
            PH_0:    first_d  = 1'b1;
            PH_1:    second_d = 1'b1;
            PH_2:    first_d  = 1'b0;
            PH_3:    second_d = 1'b0;
            default: first_d  = first_q;
          endcase
          phase_d = dir_q ? mdq_phase_e'(phase_q + 2'd1) : mdq_phase_e'(phase_q - 2'd1);
          dist_d  = dist_q - DISTANCE_BITS'(1);
        end else begin
          phase_d = PH_0;
        end
      end else begin
        cnt_d = PERIOD_W'(cnt_q + PERIOD_W'(1));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_q   <= '0;
      dir_q    <= 1'b0;
      phase_q  <= PH_0;
      period_q <= '0;
      reload_q <= RELOAD_RST;
      cnt_q    <= '0;
      first_q  <= 1'b0;
      second_q <= 1'b0;
    end else begin
      dist_q   <= dist_d;
      dir_q    <= dir_d;
      phase_q  <= phase_d;
      period_q <= period_d;
      reload_q <= reload_d;
      cnt_q    <= cnt_d;
      first_q  <= first_d;
      second_q <= second_d;
    end
  end

  assign first_o  = first_q;
  assign second_o = second_q;

endmodule

>>> hw/rtl/mdq_datapath.sv
// Datapath: configuration registers, item register, two axis lanes, buttons, output register.
module mdq_datapath import mdq_pkg::*; #(
  parameter int unsigned DPI_DIVISOR   = DPI_DIVISOR_DEF,
  parameter int unsigned DISTANCE_BITS = DIST_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mdq_cmd_t             cmd_i,
  input  mdq_item_t            item_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [LIMIT_W-1:0]   cfg_wdata_i,
  output mdq_pins_t            pins_o
);

  mdq_cfg_t         cfg_q, cfg_d;
  mdq_item_t        item_q;
  logic [BTN_W-1:0] btn_q, btn_d;
  mdq_pins_t        pins_q;
  logic             report, tick;
  logic             x_a, x_b, y_a, y_b;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (mdq_reg_e'(cfg_idx_i))
        REG_DPI_DIV_EN:    cfg_d.dpi_div_en    = cfg_wdata_i[0];
        REG_RATE_LIMIT_EN: cfg_d.rate_limit_en = cfg_wdata_i[0];
        REG_RATE_FLOOR:    cfg_d.rate_floor    = cfg_wdata_i[PERIOD_W-1:0];
        REG_DIST_LIMIT:    cfg_d.dist_limit    = cfg_wdata_i;
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  assign report = cmd_i.exec && (item_q.cmd == OP_REPORT);
  assign tick   = cmd_i.exec && (item_q.cmd == OP_TICK);
  assign btn_d  = report ? item_q.buttons : btn_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dpi_div_en    <= 1'b0;
      cfg_q.rate_limit_en <= 1'b0;
      cfg_q.rate_floor    <= RATE_FLOOR_RST;
      cfg_q.dist_limit    <= DIST_LIMIT_RST;
      btn_q               <= '0;
    end else begin
      cfg_q <= cfg_d;
      btn_q <= btn_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= item_i;
    end
    if (cmd_i.load_out) begin
      pins_q.x_a    <= !x_a;
      pins_q.x_b    <= !x_b;
      pins_q.y_a    <= !y_a;
      pins_q.y_b    <= !y_b;
      pins_q.left   <= !btn_q[0];
      pins_q.right  <= !btn_q[1];
      pins_q.middle <= !btn_q[2];
    end
  end

  mdq_axis #(
    .DPI_DIVISOR  (DPI_DIVISOR),
    .DISTANCE_BITS(DISTANCE_BITS)
  ) u_axis_x (
    .clk_i,
    .rst_ni,
    .report_i(report),
    .tick_i  (tick),
    .delta_i (item_q.dx),
    .cfg_i   (cfg_q),
    .first_o (x_a),
    .second_o(x_b)
  );

  mdq_axis #(
    .DPI_DIVISOR  (DPI_DIVISOR),
    .DISTANCE_BITS(DISTANCE_BITS)
  ) u_axis_y (
    .clk_i,
    .rst_ni,
    .report_i(report),
    .tick_i  (tick),
    .delta_i (item_q.dy),
    .cfg_i   (cfg_q),
    .first_o (y_b),
    .second_o(y_a)
  );

  assign pins_o = pins_q;

endmodule

>>> hw/rtl/mdq_ctrl.sv
// Controller: sequences capture, execute and output load, and owns both handshakes.
module mdq_ctrl import mdq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output mdq_cmd_t cmd_o
);

  mdq_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = ST_PUSH;
      end
      ST_PUSH: begin
        if (slot_free) begin
          cmd_o.load_out = 1'b1;
          in_ready_o     = 1'b1;
          cmd_o.capture  = in_valid_i;
          state_d        = in_valid_i ? ST_EXEC : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> hw/rtl/mdq_checker.sv
// Port-level checker for the converter top level, with its bind.
module mdq_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [6:0] out_pins_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_pins_i))
    else $error("result pins changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("transaction accepted while previous one executes");

  a_ready_stays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i && !in_valid_i |=> in_ready_i)
    else $error("ready dropped without a transaction");

  a_hold_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i && !in_ready_i |=> (!in_ready_i || out_ready_i))
    else $error("ready raised while output is stalled and an item is pending");

endmodule

bind mouse_delta_to_quadrature_core mdq_checker u_mdq_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (item_i.valid),
  .in_ready_i (item_i.ready),
  .out_valid_i(result_o.valid),
  .out_ready_i(result_o.ready),
  .out_pins_i ({result_o.x_a_pin, result_o.x_b_pin, result_o.y_a_pin, result_o.y_b_pin,
                result_o.left_pin, result_o.right_pin, result_o.middle_pin})
);
